@@ rtl/erm_pkg.sv @@
// ----------------------------------------------------------------------------
// erm_pkg
// types, constants and the arctangent table of the rotation matrix packer
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int CordicSteps = 30;
  localparam int LaneW       = 33;
  localparam int TrigW       = 32;
  localparam logic signed [LaneW-1:0] CordicGain = 33'sd652032874;
  localparam logic signed [TrigW-1:0] Q30One     = 32'sd1073741824;

  typedef struct packed {
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } erm_in_t;

  typedef struct packed {
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
    logic [31:0] word_four;
    logic [31:0] word_five;
  } erm_out_t;

  typedef struct packed {
    logic signed [LaneW-1:0] x;
    logic signed [LaneW-1:0] y;
    logic signed [LaneW-1:0] z;
  } erm_lane_t;

  typedef struct packed {
    logic              vld;
    erm_lane_t [2:0]   lane;
    logic [2:0][1:0]   quad;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
  } erm_cell_t;

  function automatic logic signed [LaneW-1:0] erm_atan(input logic [4:0] i);
    logic signed [LaneW-1:0] a;
    unique case (i)
      5'd0:  a = 33'sd536870912;
      5'd1:  a = 33'sd316933406;
      5'd2:  a = 33'sd167458907;
      5'd3:  a = 33'sd85004756;
      5'd4:  a = 33'sd42667331;
      5'd5:  a = 33'sd21354465;
      5'd6:  a = 33'sd10679838;
      5'd7:  a = 33'sd5340245;
      5'd8:  a = 33'sd2670163;
      5'd9:  a = 33'sd1335087;
      5'd10: a = 33'sd667544;
      5'd11: a = 33'sd333772;
      5'd12: a = 33'sd166886;
      5'd13: a = 33'sd83443;
      5'd14: a = 33'sd41722;
      5'd15: a = 33'sd20861;
      5'd16: a = 33'sd10430;
      5'd17: a = 33'sd5215;
      5'd18: a = 33'sd2608;
      5'd19: a = 33'sd1304;
      5'd20: a = 33'sd652;
      5'd21: a = 33'sd326;
      5'd22: a = 33'sd163;
      5'd23: a = 33'sd81;
      5'd24: a = 33'sd41;
      5'd25: a = 33'sd20;
      5'd26: a = 33'sd10;
      5'd27: a = 33'sd5;
      5'd28: a = 33'sd3;
      5'd29: a = 33'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/euler_rotation_matrix_packer_unit.sv @@
// ----------------------------------------------------------------------------
// euler_rotation_matrix_packer_unit
// rotation matrix rz*ry*rx in q15 packed with screen positions
//
//   channel | ports                        | payload
//   input   | in_valid, in_ready, in_data  | three angles, two positions
//   output  | out_valid, out_ready, out_data | six packed 32-bit words
//
// one transfer per cycle while the output is not stalled; 30 cordic cells, then five
// stages for quadrant fold, two product levels, sums and entry scaling
// reset is synchronous and clears only the valid bits of the chain
// a stalled output freezes the whole chain, so in_ready drops while out_valid waits on out_ready
// ----------------------------------------------------------------------------
module euler_rotation_matrix_packer_unit import erm_pkg::*; #(
  parameter int ENTRY_SCALE = 32767
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  erm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output erm_out_t out_data
);

  logic en;
  erm_cell_t chain [CordicSteps+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    chain[0].vld          = in_valid;
    chain[0].pos_x        = in_data.pos_x;
    chain[0].pos_y        = in_data.pos_y;
    chain[0].quad[0]      = in_data.angle_x[15:14];
    chain[0].quad[1]      = in_data.angle_y[15:14];
    chain[0].quad[2]      = in_data.angle_z[15:14];
    chain[0].lane[0].z    = LaneW'({in_data.angle_x[13:0], 16'h0000});
    chain[0].lane[1].z    = LaneW'({in_data.angle_y[13:0], 16'h0000});
    chain[0].lane[2].z    = LaneW'({in_data.angle_z[13:0], 16'h0000});
    for (int l = 0; l < 3; l++) begin
      chain[0].lane[l].x = CordicGain;
      chain[0].lane[l].y = '0;
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    erm_cordic_cell #(.STEP(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (chain[g]),
      .q     (chain[g+1])
    );
  end

  erm_matrix #(.ENTRY_SCALE(ENTRY_SCALE)) u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .d        (chain[CordicSteps]),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  a_w5_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.word_five[15:0] == 16'h0000)
    else $error("word five low half not zero");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.word_four[31:16] != 16'h8000
                  && out_data.word_zero[31:16] != 16'h8000)
    else $error("entry outside saturation range");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

endmodule

@@ rtl/erm_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// erm_cordic_cell
// one cordic micro-rotation for the three angle lanes, registered
// ----------------------------------------------------------------------------
module erm_cordic_cell import erm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  erm_cell_t d,
  output erm_cell_t q
);

  erm_cell_t q_r, q_nxt;
  localparam logic signed [LaneW-1:0] Atan = erm_atan(5'(STEP));

  always_comb begin
    q_nxt = d;
    for (int l = 0; l < 3; l++) begin
      if (!d.lane[l].z[LaneW-1]) begin
        q_nxt.lane[l].x = d.lane[l].x - (d.lane[l].y >>> STEP);
        q_nxt.lane[l].y = d.lane[l].y + (d.lane[l].x >>> STEP);
        q_nxt.lane[l].z = d.lane[l].z - Atan;
      end else begin
        q_nxt.lane[l].x = d.lane[l].x + (d.lane[l].y >>> STEP);
        q_nxt.lane[l].y = d.lane[l].y - (d.lane[l].x >>> STEP);
        q_nxt.lane[l].z = d.lane[l].z + Atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= q_nxt.vld;
    end
    if (en) begin
      q_r.lane  <= q_nxt.lane;
      q_r.quad  <= q_nxt.quad;
      q_r.pos_x <= q_nxt.pos_x;
      q_r.pos_y <= q_nxt.pos_y;
    end
  end

  assign q = q_r;

endmodule

@@ rtl/erm_matrix.sv @@
// ----------------------------------------------------------------------------
// erm_matrix
// quadrant fold, q30 products, sums and q15 entry packing
// ----------------------------------------------------------------------------
module erm_matrix import erm_pkg::*; #(
  parameter int ENTRY_SCALE = 32767
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  erm_cell_t d,
  output logic      out_vld,
  output erm_out_t  out_data
);

  typedef logic signed [TrigW-1:0] trig_t;

  function automatic trig_t clamp(input logic signed [LaneW-1:0] v);
    if (v > LaneW'(Q30One)) return Q30One;
    if (v < -LaneW'(Q30One)) return -Q30One;
    return TrigW'(v);
  endfunction

  function automatic trig_t qmul(input trig_t a, input trig_t b);
    logic signed [2*TrigW-1:0] p;
    p = a * b;
    return TrigW'(p >>> 30);
  endfunction

  function automatic logic [15:0] to_entry(input logic signed [TrigW:0] v);
    logic [TrigW:0] mag;
    logic [TrigW+15:0] prod;
    logic [17:0] sh;
    logic [15:0] m16;
    mag  = v[TrigW] ? (~v + 1'b1) : v;
    prod = (TrigW+16)'(mag) * (TrigW+16)'(ENTRY_SCALE);
    sh   = prod[TrigW+15:30] > (TrigW-14)'(ENTRY_SCALE) ? 18'(ENTRY_SCALE)
                                                         : 18'(prod[TrigW+15:30]);
    m16  = sh[15:0];
    return v[TrigW] ? (~m16 + 1'b1) : m16;
  endfunction

  // stage 1: sin and cos
  logic s1_vld_r;
  trig_t [2:0] c1_r, s1_r;
  logic [15:0] px1_r, py1_r;

  // stage 2: first products
  logic s2_vld_r;
  trig_t czsy2_r, szsy2_r, czcy2_r, szcy2_r, cysx2_r, cycx2_r;
  trig_t szcx2_r, szsx2_r, czcx2_r, czsx2_r, sx2_r, cx2_r, sy2_r;
  logic [15:0] px2_r, py2_r;

  // stage 3: second products
  logic s3_vld_r;
  trig_t a3_r, b3_r, e3_r, f3_r;
  trig_t czcy3_r, szcy3_r, cysx3_r, cycx3_r, szcx3_r, szsx3_r, czcx3_r, czsx3_r, sy3_r;
  logic [15:0] px3_r, py3_r;

  // stage 4: sums
  logic s4_vld_r;
  logic signed [TrigW:0] v4_r [9];
  logic [15:0] px4_r, py4_r;

  // stage 5: entries
  logic s5_vld_r;
  erm_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= d.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        case (d.quad[l])
          2'd0: begin
            c1_r[l] <= clamp(d.lane[l].x);
            s1_r[l] <= clamp(d.lane[l].y);
          end
          2'd1: begin
            c1_r[l] <= -clamp(d.lane[l].y);
            s1_r[l] <= clamp(d.lane[l].x);
          end
          2'd2: begin
            c1_r[l] <= -clamp(d.lane[l].x);
            s1_r[l] <= -clamp(d.lane[l].y);
          end
          default: begin
            c1_r[l] <= clamp(d.lane[l].y);
            s1_r[l] <= -clamp(d.lane[l].x);
          end
        endcase
      end
      px1_r <= d.pos_x;
      py1_r <= d.pos_y;

      czsy2_r <= qmul(c1_r[2], s1_r[1]);
      szsy2_r <= qmul(s1_r[2], s1_r[1]);
      czcy2_r <= qmul(c1_r[2], c1_r[1]);
      szcy2_r <= qmul(s1_r[2], c1_r[1]);
      cysx2_r <= qmul(c1_r[1], s1_r[0]);
      cycx2_r <= qmul(c1_r[1], c1_r[0]);
      szcx2_r <= qmul(s1_r[2], c1_r[0]);
      szsx2_r <= qmul(s1_r[2], s1_r[0]);
      czcx2_r <= qmul(c1_r[2], c1_r[0]);
      czsx2_r <= qmul(c1_r[2], s1_r[0]);
      sx2_r   <= s1_r[0];
      cx2_r   <= c1_r[0];
      sy2_r   <= s1_r[1];
      px2_r   <= px1_r;
      py2_r   <= py1_r;

      a3_r    <= qmul(czsy2_r, sx2_r);
      b3_r    <= qmul(czsy2_r, cx2_r);
      e3_r    <= qmul(szsy2_r, sx2_r);
      f3_r    <= qmul(szsy2_r, cx2_r);
      czcy3_r <= czcy2_r;
      szcy3_r <= szcy2_r;
      cysx3_r <= cysx2_r;
      cycx3_r <= cycx2_r;
      szcx3_r <= szcx2_r;
      szsx3_r <= szsx2_r;
      czcx3_r <= czcx2_r;
      czsx3_r <= czsx2_r;
      sy3_r   <= sy2_r;
      px3_r   <= px2_r;
      py3_r   <= py2_r;

      v4_r[0] <= 33'(czcy3_r);
      v4_r[1] <= 33'(a3_r) - 33'(szcx3_r);
      v4_r[2] <= 33'(b3_r) + 33'(szsx3_r);
      v4_r[3] <= 33'(szcy3_r);
      v4_r[4] <= 33'(e3_r) + 33'(czcx3_r);
      v4_r[5] <= 33'(f3_r) - 33'(czsx3_r);
      v4_r[6] <= -33'(sy3_r);
      v4_r[7] <= 33'(cysx3_r);
      v4_r[8] <= 33'(cycx3_r);
      px4_r   <= px3_r;
      py4_r   <= py3_r;

      out_r.word_zero  <= {to_entry(v4_r[0]), to_entry(v4_r[1])};
      out_r.word_one   <= {to_entry(v4_r[2]), px4_r};
      out_r.word_two   <= {to_entry(v4_r[3]), to_entry(v4_r[4])};
      out_r.word_three <= {to_entry(v4_r[5]), py4_r};
      out_r.word_four  <= {to_entry(v4_r[6]), to_entry(v4_r[7])};
      out_r.word_five  <= {to_entry(v4_r[8]), 16'h0000};
    end
  end

  assign out_vld  = s5_vld_r;
  assign out_data = out_r;

endmodule

@@ sim/tb_euler_rotation_matrix_packer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_rotation_matrix_packer_unit
// checks the packed q15 rotation matrix against a cordic-based predictor;
// a directed table of angle and position corners, then random transfers
// with random idling on both channels and a scoreboard of pending words
// ----------------------------------------------------------------------------
module tb_euler_rotation_matrix_packer_unit import erm_pkg::*;;

  localparam int EntryScale = 32767;
  localparam int NumRandom  = 1100;
  localparam int Latency    = 35;

  typedef struct {
    erm_in_t  stim;
    logic     has_exp;
    erm_out_t exp;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  erm_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  erm_out_t out_data;

  erm_out_t pending_words[$];
  dir_row_t dir_rows[$];
  int       errors;
  logic     quiet;

  euler_rotation_matrix_packer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_q30(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint tab[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
    return tab[i];
  endfunction

  task automatic angle_trig(input logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(ang[13:0]) << 16;
    for (int i = 0; i < 30; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    x = clamp_q30(x);
    y = clamp_q30(y);
    case (ang[15:14])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic logic [15:0] q15_entry(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * EntryScale) >>> 30;
    if (mag > EntryScale) mag = EntryScale;
    if (v < 0) mag = -mag;
    return mag[15:0];
  endfunction

  task automatic predict_matrix(input erm_in_t d, output erm_out_t r);
    longint cx, sx, cy, sy, cz, sz, czsy, szsy;
    angle_trig(d.angle_x, cx, sx);
    angle_trig(d.angle_y, cy, sy);
    angle_trig(d.angle_z, cz, sz);
    czsy = q30_mul(cz, sy);
    szsy = q30_mul(sz, sy);
    r.word_zero  = {q15_entry(q30_mul(cz, cy)),
                    q15_entry(q30_mul(czsy, sx) - q30_mul(sz, cx))};
    r.word_one   = {q15_entry(q30_mul(czsy, cx) + q30_mul(sz, sx)), d.pos_x};
    r.word_two   = {q15_entry(q30_mul(sz, cy)),
                    q15_entry(q30_mul(szsy, sx) + q30_mul(cz, cx))};
    r.word_three = {q15_entry(q30_mul(szsy, cx) - q30_mul(cz, sx)), d.pos_y};
    r.word_four  = {q15_entry(-sy), q15_entry(q30_mul(cy, sx))};
    r.word_five  = {q15_entry(q30_mul(cy, cx)), 16'h0000};
  endtask

  function automatic dir_row_t mk_row(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                      logic [15:0] px, logic [15:0] py, logic known,
                                      erm_out_t e);
    dir_row_t r;
    r.stim = '{angle_x: ax, angle_y: ay, angle_z: az, pos_x: px, pos_y: py};
    r.has_exp = known;
    r.exp = e;
    return r;
  endfunction

  function automatic logic idle_now();
    return !quiet && ($urandom_range(0, 99) < 7);
  endfunction

  task automatic send_item(input erm_in_t d);
    if (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (idle_now()) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(16'h4000 * $urandom_range(0, 3));
      1: return 16'(16'h4000 * $urandom_range(0, 4) + $urandom_range(0, 6) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      erm_out_t e;
      predict_matrix(in_data, e);
      pending_words.push_back(e);
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual %h", $realtime, out_data);
        errors++;
      end else begin
        erm_out_t e;
        e = pending_words.pop_front();
        if (out_data.word_zero !== e.word_zero) begin
          $display("%0t word_zero: expected %h, actual %h", $realtime, e.word_zero,
                   out_data.word_zero);
          errors++;
        end
        if (out_data.word_one !== e.word_one) begin
          $display("%0t word_one: expected %h, actual %h", $realtime, e.word_one,
                   out_data.word_one);
          errors++;
        end
        if (out_data.word_two !== e.word_two) begin
          $display("%0t word_two: expected %h, actual %h", $realtime, e.word_two,
                   out_data.word_two);
          errors++;
        end
        if (out_data.word_three !== e.word_three) begin
          $display("%0t word_three: expected %h, actual %h", $realtime, e.word_three,
                   out_data.word_three);
          errors++;
        end
        if (out_data.word_four !== e.word_four) begin
          $display("%0t word_four: expected %h, actual %h", $realtime, e.word_four,
                   out_data.word_four);
          errors++;
        end
        if (out_data.word_five !== e.word_five) begin
          $display("%0t word_five: expected %h, actual %h", $realtime, e.word_five,
                   out_data.word_five);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !idle_now();
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    erm_out_t e;
    erm_out_t ident;
    erm_in_t  d;
    int       waited;
    errors    = 0;
    quiet     = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    ident = '0;
    // positions pass through, low half of word five stays zero
    dir_rows.push_back(mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, ident));
    e = ident; e.word_one[15:0] = 16'hFFFF; e.word_three[15:0] = 16'hFFFF;
    dir_rows.push_back(mk_row(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, e));
    e = ident; e.word_one[15:0] = 16'hAAAA; e.word_three[15:0] = 16'h5555;
    dir_rows.push_back(mk_row(16'h0000, 16'h0000, 16'h0000, 16'hAAAA, 16'h5555, 1'b1, e));
    dir_rows.push_back(mk_row(16'h4000, 16'h0000, 16'h0000, 16'h5555, 16'hAAAA, 1'b0, e));
    dir_rows.push_back(mk_row(16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'h8000, 1'b0, e));
    dir_rows.push_back(mk_row(16'hC000, 16'h0000, 16'h0000, 16'h8000, 16'h0001, 1'b0, e));
    dir_rows.push_back(mk_row(16'h0000, 16'h4000, 16'h0000, 16'h1234, 16'h4321, 1'b0, e));
    dir_rows.push_back(mk_row(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, e));
    dir_rows.push_back(mk_row(16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 1'b0, e));
    dir_rows.push_back(mk_row(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 1'b0, e));
    dir_rows.push_back(mk_row(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0, e));
    dir_rows.push_back(mk_row(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 1'b0, e));
    dir_rows.push_back(mk_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, e));
    dir_rows.push_back(mk_row(16'h3FFF, 16'h7FFF, 16'hBFFF, 16'h0000, 16'hFFFF, 1'b0, e));
    dir_rows.push_back(mk_row(16'h2000, 16'h2000, 16'h2000, 16'h00FF, 16'hFF00, 1'b0, e));
    dir_rows.push_back(mk_row(16'h0001, 16'h4001, 16'h8001, 16'hC001, 16'h0001, 1'b0, e));
    dir_rows.push_back(mk_row(16'hE000, 16'h6000, 16'hA000, 16'h7FFF, 16'h8000, 1'b0, e));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        predict_matrix(dir_rows[i].stim, e);
        if (e.word_one[15:0] !== dir_rows[i].exp.word_one[15:0]
            || e.word_three[15:0] !== dir_rows[i].exp.word_three[15:0]
            || e.word_five[15:0] !== dir_rows[i].exp.word_five[15:0]) begin
          $display("%0t table row %0d: expected %h, actual %h", $realtime, i,
                   dir_rows[i].exp, e);
          errors++;
        end
      end
      send_item(dir_rows[i].stim);
    end
    for (int n = 0; n < NumRandom; n++) begin
      quiet = (n >= 400 && n < 600);
      d.angle_x = rand_angle();
      d.angle_y = rand_angle();
      d.angle_z = rand_angle();
      d.pos_x   = 16'($urandom);
      d.pos_y   = 16'($urandom);
      send_item(d);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;
    waited = 0;
    while (pending_words.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/erm_pkg.sv
rtl/erm_cordic_cell.sv
rtl/erm_matrix.sv
rtl/euler_rotation_matrix_packer_unit.sv
sim/tb_euler_rotation_matrix_packer_unit.sv
